/* rtl/rgbhsl_pkg.sv */
package rgbhsl_pkg;

    // Result field widths.
    localparam int HUE_BITS = 9;
    localparam int SAT_BITS = 7;
    localparam int LIT_BITS = 7;

    // Every divider resolves this many quotient bits, one per stage.
    // All three quotients stay below 2**QUOT_BITS.
    localparam int QUOT_BITS = 9;

    // Scale factors of the rounded divisions.
    localparam int HUE_SECTOR = 60;
    localparam int PCT_TWICE  = 200;

endpackage

/* rtl/rgbhsl_front.sv */
module rgbhsl_front #(
    parameter int N  = 8,
    parameter int DW = N + 10,
    parameter int VW = N + 2
) (
    input  logic          clk,
    input  logic          en,
    input  logic [N-1:0]  red,
    input  logic [N-1:0]  green,
    input  logic [N-1:0]  blue,
    output logic [DW-1:0] hue_num,
    output logic [VW-1:0] hue_den,
    output logic [DW-1:0] sat_num,
    output logic [VW-1:0] sat_den,
    output logic [DW-1:0] lit_num
);
    import rgbhsl_pkg::*;

    localparam int          HW   = N + 9;
    localparam int unsigned MAXV = (1 << N) - 1;

    logic [N-1:0]  mx, mn, d;
    logic [N:0]    sum, den;
    logic [HW-1:0] sect;
    logic          gray;

    logic [DW-1:0] hue_num_next, sat_num_next, lit_num_next;
    logic [VW-1:0] hue_den_next, sat_den_next;
    logic [DW-1:0] hue_num_reg, sat_num_reg, lit_num_reg;
    logic [VW-1:0] hue_den_reg, sat_den_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        d    = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        gray = (d == '0);

        // Sector numerator, kept non-negative (red sector wraps by 360 d).
        if (mx == red) begin
            if (green >= blue)
                sect = HW'(green - blue) * HW'(HUE_SECTOR);
            else
                sect = HW'(d) * HW'(6 * HUE_SECTOR) - HW'(blue - green) * HW'(HUE_SECTOR);
        end else if (mx == green) begin
            sect = HW'(d) * HW'(2 * HUE_SECTOR) + HW'(blue) * HW'(HUE_SECTOR)
                 - HW'(red) * HW'(HUE_SECTOR);
        end else begin
            sect = HW'(d) * HW'(4 * HUE_SECTOR) + HW'(red) * HW'(HUE_SECTOR)
                 - HW'(green) * HW'(HUE_SECTOR);
        end

        if (sum < (N+1)'(MAXV))
            den = sum;
        else
            den = (N+1)'(2 * MAXV) - sum;

        // Rounded a/b is floor((2a + b) / 2b). Gray forces 0 / 1.
        if (gray) begin
            hue_num_next = '0;
            hue_den_next = VW'(1);
            sat_num_next = '0;
            sat_den_next = VW'(1);
        end else begin
            hue_num_next = {sect, 1'b0} + DW'(d);
            hue_den_next = {1'b0, d, 1'b0};
            sat_num_next = DW'(d) * DW'(PCT_TWICE) + DW'(den);
            sat_den_next = {den, 1'b0};
        end
        lit_num_next = DW'(sum) * DW'(PCT_TWICE) + DW'(2 * MAXV);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            lit_num_reg <= lit_num_next;
        end
    end

    assign hue_num = hue_num_reg;
    assign hue_den = hue_den_reg;
    assign sat_num = sat_num_reg;
    assign sat_den = sat_den_reg;
    assign lit_num = lit_num_reg;

endmodule

/* rtl/rgbhsl_div.sv */
module rgbhsl_div #(
    parameter int DW = 18,
    parameter int VW = 10,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic [QW-1:0] en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient
);
    import rgbhsl_pkg::*;

    // Restoring long division, one quotient bit per stage, most significant
    // first. The dividend must stay below divisor * 2**QW.
    logic [DW-1:0] rem_reg [QW-1];
    logic [VW-1:0] div_reg [QW-1];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in, shifted;
        logic [VW-1:0] div_in;
        logic [QW-1:0] q_in;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
            assign div_in = divisor;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign div_in = div_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted  = DW'(div_in) << (QW - 1 - k);
        assign ge       = (rem_in >= shifted);

        always_ff @(posedge clk)
        begin
            if (en[k])
                q_reg[k] <= {q_in[QW-2:0], ge};
        end

        if (k < QW - 1)
        begin : g_carry
            logic [DW-1:0] rem_next;

            assign rem_next = ge ? (rem_in - shifted) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    div_reg[k] <= div_in;
                end
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

/* rtl/rgb_to_hsl_integer_unit.sv */
// RGB to HSL converter with exact integer arithmetic and half-up rounding.
// Input channel: s_tvalid / s_tready / s_tdata carries one pixel per item,
// red, green and blue of CHANNEL_BITS each, red in the lowest bits.
// Output channel: m_tvalid / m_tready / m_tdata carries hue in degrees
// (0 to 360), saturation and lightness in percent (0 to 100).
// A gray pixel gives hue 0 and saturation 0.
// On the path from acceptance to the result appearing, one stage
// finds max, min and the sector numerator, then nine stages of restoring
// division resolve one quotient bit each for hue and saturation in parallel.
// Lightness divides by a constant, so it takes a reciprocal multiply, one
// correction step, and then a delay line that keeps it aligned with the rest.
// One item is accepted every cycle while the output is taken.
// Each stage holds a valid bit; a stage loads whenever it is empty or its
// successor loads, so bubbles collapse under a stall and a stalled output
// item simply holds while the stages behind it keep filling.
// s_tready drops only once every stage holds an item and m_tready is low.
// Reset clears all valid bits; data registers are not reset.
module rgb_to_hsl_integer_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata: red, green, blue (lowest first), zero-filled to whole bytes
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata: hue[8:0], saturation[15:9], lightness[22:16], bit 23 zero
    output logic [((rgbhsl_pkg::HUE_BITS + rgbhsl_pkg::SAT_BITS
                    + rgbhsl_pkg::LIT_BITS + 7)/8)*8-1:0] m_tdata
);
    import rgbhsl_pkg::*;

    localparam int N      = CHANNEL_BITS;
    localparam int DW     = N + 10;
    localparam int VW     = N + 2;
    localparam int STAGES = QUOT_BITS + 1;
    localparam int OW     = HUE_BITS + SAT_BITS + LIT_BITS;
    localparam int OBW    = ((OW + 7) / 8) * 8;

    // Lightness divisor and its truncated reciprocal scaled by 2**DW. The
    // estimate is at most one below the true quotient, so one correction
    // step finishes the division.
    localparam int          RW        = DW - N;
    localparam int unsigned LIT_DEN   = 4 * ((1 << N) - 1);
    localparam int unsigned LIT_RECIP = (1 << DW) / LIT_DEN;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES:0]   load;

    logic [DW-1:0] hue_num, sat_num, lit_num;
    logic [VW-1:0] hue_den, sat_den;
    logic [QUOT_BITS-1:0] hue_q, sat_q, lit_q;

    logic [DW+RW-1:0]     lit_prod;
    logic [DW-1:0]        lit_rem;
    logic [QUOT_BITS-1:0] lit_est_next, lit_fix_next;
    logic [DW-1:0]        lit_arg_reg;
    logic [QUOT_BITS-1:0] lit_est_reg;
    logic [QUOT_BITS-1:0] lit_dly_reg [STAGES-2];

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb
    begin
        load[STAGES] = m_tready;
        for (int i = STAGES - 1; i >= 0; i--)
            load[i] = !valid_reg[i] || load[i+1];
        valid_next = valid_reg;
        if (load[0])
            valid_next[0] = s_tvalid;
        for (int i = 1; i < STAGES; i++)
        begin
            if (load[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[STAGES-1];

    rgbhsl_front #(.N(N), .DW(DW), .VW(VW)) u_front (
        .clk     (clk),
        .en      (load[0]),
        .red     (s_tdata[N-1:0]),
        .green   (s_tdata[2*N-1:N]),
        .blue    (s_tdata[3*N-1:2*N]),
        .hue_num (hue_num),
        .hue_den (hue_den),
        .sat_num (sat_num),
        .sat_den (sat_den),
        .lit_num (lit_num)
    );

    rgbhsl_div #(.DW(DW), .VW(VW), .QW(QUOT_BITS)) u_hue_div (
        .clk      (clk),
        .en       (load[STAGES-1:1]),
        .dividend (hue_num),
        .divisor  (hue_den),
        .quotient (hue_q)
    );

    rgbhsl_div #(.DW(DW), .VW(VW), .QW(QUOT_BITS)) u_sat_div (
        .clk      (clk),
        .en       (load[STAGES-1:1]),
        .dividend (sat_num),
        .divisor  (sat_den),
        .quotient (sat_q)
    );

    // Lightness: the first stage estimates the quotient with the reciprocal,
    // the second adds one where the remainder still reaches the divisor.
    always_comb
    begin
        lit_prod     = (DW+RW)'(lit_num) * (DW+RW)'(LIT_RECIP);
        lit_est_next = lit_prod[DW +: QUOT_BITS];
        lit_rem      = lit_arg_reg - DW'(lit_est_reg) * DW'(LIT_DEN);
        lit_fix_next = lit_est_reg + QUOT_BITS'(lit_rem >= DW'(LIT_DEN));
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            lit_arg_reg <= lit_num;
            lit_est_reg <= lit_est_next;
        end
        if (load[2])
            lit_dly_reg[0] <= lit_fix_next;
        for (int j = 1; j < STAGES - 2; j++)
        begin
            if (load[j+2])
                lit_dly_reg[j] <= lit_dly_reg[j-1];
        end
    end

    assign lit_q = lit_dly_reg[STAGES-3];

    assign m_tdata = {{(OBW-OW){1'b0}}, lit_q[LIT_BITS-1:0], sat_q[SAT_BITS-1:0],
                      hue_q[HUE_BITS-1:0]};

    // Results stay within their documented ranges.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (hue_q <= QUOT_BITS'(360)))
        else $error("hue above 360");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sat_q <= QUOT_BITS'(100)))
        else $error("saturation above 100");

    a_lit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (lit_q <= QUOT_BITS'(100)))
        else $error("lightness above 100");

    // An item waiting at the output must not be overwritten by a stall.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !load[STAGES-1])
        else $error("output stage loaded while stalled");

endmodule
